/* design/sentence_boundary_detector_core_macros.svh */
`ifndef SENTENCE_BOUNDARY_DETECTOR_CORE_MACROS_SVH
`define SENTENCE_BOUNDARY_DETECTOR_CORE_MACROS_SVH

// Checks that hold on every edge outside reset.
`define SBD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define SBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sbd_pkg.sv */
`default_nettype none

package sbd_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int POS_BITS    = 32;
	localparam int CFG_BITS    = 16;
	localparam int REASON_BITS = 3;

	localparam logic [CFG_BITS-1:0] MAX_LENGTH_RESET = CFG_BITS'(1024);
	localparam logic [POS_BITS-1:0] LEN_MASK =
		POS_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

	// Output queue
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// End reasons
	localparam logic [REASON_BITS-1:0] R_PUNCT = 3'd0;
	localparam logic [REASON_BITS-1:0] R_LINE  = 3'd1;
	localparam logic [REASON_BITS-1:0] R_SPACE = 3'd2;
	localparam logic [REASON_BITS-1:0] R_HARD  = 3'd3;
	localparam logic [REASON_BITS-1:0] R_EOT   = 3'd4;

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;

	typedef struct packed {
		logic [POS_BITS-1:0]    start_pos;
		logic [POS_BITS-1:0]    end_pos;
		logic [REASON_BITS-1:0] reason;
		logic                   last;
	} res_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {CH_SPACE, [CH_TAB:CH_CR]};
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return b inside {CH_QUESTION, CH_BANG, CH_DOT};
	endfunction

endpackage

`default_nettype wire

/* design/sentence_boundary_detector_core.sv */
// Sentence boundary detector.
// Input stream: one text byte per request on s_tdata; s_tlast marks end of
// text (the byte is then ignored) and flushes the pending sentence.
// Output stream: one sentence per request, start and exclusive end position
// on m_tdata, end reason on m_tuser, m_tlast on the final sentence that one
// input request caused (an input gives zero, one or two sentences).
// cfg_wen/cfg_wdata set the maximum sentence length; write only while idle.
// A sentence enters the output queue when its byte is taken; m_tvalid shows the oldest one.
// Throughput: one byte per cycle while s_tready is high. The byte is classified and the position,
// length and last-space registers are updated in the cycle it is accepted;
// results go into a four-entry output queue. s_tready is high while the
// queue has room for two results, so a stalled receiver backs up the input
// after at most four pending results and nothing is dropped.
// Reset clears positions, the pending sentence and the queue, and sets the
// maximum length to 1024.
`default_nettype none

`include "sentence_boundary_detector_core_macros.svh"

module sentence_boundary_detector_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] char_byte
	input  wire logic                           s_tlast,   // flush
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [2*sbd_pkg::POS_BITS-1:0]      m_tdata,   // [31:0] sentence_start, [63:32] sentence_end
	output logic [sbd_pkg::REASON_BITS-1:0]     m_tuser,   // [2:0] end_reason
	output logic                                m_tlast,   // last_of_run
	input  wire logic                           cfg_wen,
	input  wire logic [sbd_pkg::CFG_BITS-1:0]   cfg_wdata  // [15:0] max_length
);
	import sbd_pkg::*;

	logic [CFG_BITS-1:0]    max_q;
	logic [POS_BITS-1:0]    pos_q, start_q;
	logic [LENGTH_BITS-1:0] len_q, off_q;
	logic                   seen_q;

	logic [POS_BITS-1:0]    pos_n, start_n;
	logic [LENGTH_BITS-1:0] len_n, off_n;
	logic                   seen_n;

	res_t                   q_mem [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	logic                   in_acc, out_acc;
	logic [1:0]             n_res;
	res_t                   res0, res1;

	logic [POS_BITS-1:0]    eff_max, len_w, off_w, pos_inc, st1;
	logic [LENGTH_BITS-1:0] len1;
	logic                   seen1, cut, sp_ok;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign s_tready = (count_q <= QCNT_BITS'(QDEPTH - 2));

	assign len_w   = POS_BITS'(len_q);
	assign off_w   = POS_BITS'(off_q);
	assign pos_inc = pos_q + POS_BITS'(1);

	// Zero acts as one; clamp to what the length counter can hold.
	always_comb begin
		eff_max = (max_q == '0) ? POS_BITS'(1) : POS_BITS'(max_q);
		if (eff_max > LEN_MASK) begin
			eff_max = LEN_MASK;
		end
	end

	assign cut   = (len_w >= eff_max);
	assign sp_ok = seen_q && (off_q != '0) && (off_q < len_q);

	always_comb begin
		pos_n   = pos_q;
		start_n = start_q;
		len_n   = len_q;
		off_n   = off_q;
		seen_n  = seen_q;
		n_res   = 2'd0;
		res0    = '{start_pos: start_q, end_pos: start_q + len_w, reason: R_EOT, last: 1'b1};
		res1    = '{start_pos: start_q, end_pos: pos_inc, reason: R_PUNCT, last: 1'b1};
		st1     = start_q;
		len1    = len_q;
		seen1   = seen_q;

		if (s_tlast) begin
			if (len_q != '0) begin
				n_res = 2'd1;
			end
			start_n = pos_q;
			len_n   = '0;
			seen_n  = 1'b0;
		end else if (s_tdata == CH_NEWLINE) begin
			if (len_q != '0) begin
				n_res       = 2'd1;
				res0.reason = R_LINE;
			end
			start_n = pos_inc;
			len_n   = '0;
			seen_n  = 1'b0;
			pos_n   = pos_inc;
		end else begin
			if (cut) begin
				n_res     = 2'd1;
				res0.last = !is_punct(s_tdata);
				if (sp_ok) begin
					res0.end_pos = start_q + off_w;
					res0.reason  = R_SPACE;
					st1          = start_q + off_w;
					len1         = len_q - off_q;
				end else begin
					res0.reason = R_HARD;
					st1         = start_q + len_w;
					len1        = '0;
				end
				seen1 = 1'b0;
			end

			if (is_punct(s_tdata)) begin
				// Mark closes the sentence; it is the first or second result.
				if (cut) begin
					n_res = 2'd2;
					res1.start_pos = st1;
				end else begin
					n_res = 2'd1;
					res0  = '{start_pos: st1, end_pos: pos_inc, reason: R_PUNCT, last: 1'b1};
				end
				start_n = pos_inc;
				len_n   = '0;
				seen_n  = 1'b0;
			end else begin
				start_n = st1;
				seen_n  = seen1;
				if (is_ws(s_tdata) && (len1 != '0)) begin
					off_n  = len1;
					seen_n = 1'b1;
				end
				len_n = len1 + LENGTH_BITS'(1);
			end
			pos_n = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_LENGTH_RESET;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			off_q   <= '0;
			seen_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_q <= cfg_wdata;
			end
			if (in_acc) begin
				pos_q   <= pos_n;
				start_q <= start_n;
				len_q   <= len_n;
				off_q   <= off_n;
				seen_q  <= seen_n;
			end
		end
	end

	// Output queue: push up to two results, pop one.
	always_ff @(posedge clk) begin
		if (in_acc && (n_res != 2'd0)) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (in_acc && (n_res == 2'd2)) begin
			q_mem[wr_ptr_q + QPTR_BITS'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_res);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + (in_acc ? QCNT_BITS'(n_res) : '0)
				- (out_acc ? QCNT_BITS'(1) : '0);
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {q_mem[rd_ptr_q].end_pos, q_mem[rd_ptr_q].start_pos};
	assign m_tuser  = q_mem[rd_ptr_q].reason;
	assign m_tlast  = q_mem[rd_ptr_q].last;

	`SBD_ASSERT_ALWAYS(a_queue_bound, count_q <= QCNT_BITS'(QDEPTH), "output queue overflow")
	`SBD_ASSERT_IMP(a_pair_last, in_acc && (n_res == 2'd2), !res0.last && res1.last, "bad last flags on result pair")
	`SBD_ASSERT_IMP(a_pair_kind, in_acc && (n_res == 2'd2), ((res0.reason == R_SPACE) || (res0.reason == R_HARD)) && (res1.reason == R_PUNCT), "result pair is not cut then mark")
	`SBD_ASSERT_NEXT(a_pos_step, in_acc && !s_tlast, pos_q == $past(pos_q) + POS_BITS'(1), "stream position did not advance")
	`SBD_ASSERT_NEXT(a_flush_clear, in_acc && s_tlast, (len_q == '0) && !seen_q, "flush left a pending sentence")

endmodule

`default_nettype wire
